### sv/eqz_pkg.sv
package eqz_pkg;

  localparam int unsigned TapsDefault = 64;
  localparam int unsigned SampleW     = 16;
  localparam int unsigned CoefW       = 16;
  localparam int unsigned GainW       = 16;
  localparam int unsigned IndexW      = 6;
  localparam int unsigned NumBands    = 3;
  localparam int unsigned AccW        = 32;
  localparam int unsigned AccShift    = 15;
  localparam int unsigned BandW       = AccW - AccShift;
  localparam int unsigned GprodW      = BandW + GainW;
  localparam int unsigned SumW        = GprodW + 2;
  localparam int unsigned GainShift   = 12;
  localparam logic [AccW-1:0] RoundConst = 32'h0000_4000;
  localparam logic [GainW-1:0] GainOne   = 16'h1000;

  localparam logic [1:0] BandLow  = 2'd0;
  localparam logic [1:0] BandMid  = 2'd1;
  localparam logic [1:0] BandHigh = 2'd2;

  localparam logic [1:0] RegGainLow  = 2'd0;
  localparam logic [1:0] RegGainMid  = 2'd1;
  localparam logic [1:0] RegGainHigh = 2'd2;

  localparam logic CmdSample = 1'b0;
  localparam logic CmdCoef   = 1'b1;

  typedef enum logic [2:0] {
    StIdle,
    StMac,
    StFlush,
    StScale,
    StSum,
    StDone
  } eqz_state_e;

  // Per-cycle control broadcast along the row of cells.
  typedef struct packed {
    logic shift;   // take a new sample in at the tail
    logic rotate;  // circulate samples and coefficients by one cell
  } cell_ctrl_t;

endpackage

### sv/eqz_cell.sv
module eqz_cell (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  input  eqz_pkg::cell_ctrl_t                          ctrl_i,
  input  logic [eqz_pkg::NumBands-1:0]                 load_i,
  input  logic [eqz_pkg::CoefW-1:0]                    coef_value_i,
  input  logic [eqz_pkg::SampleW-1:0]                  sample_i,
  input  logic [eqz_pkg::NumBands-1:0][eqz_pkg::CoefW-1:0] coef_i,
  output logic [eqz_pkg::SampleW-1:0]                  sample_o,
  output logic [eqz_pkg::NumBands-1:0][eqz_pkg::CoefW-1:0] coef_o
);
  import eqz_pkg::*;

  logic [SampleW-1:0]               sample_q;
  logic [NumBands-1:0][CoefW-1:0]   coef_q;
  logic [NumBands-1:0][CoefW-1:0]   coef_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_q <= '0;
    end else if (ctrl_i.shift || ctrl_i.rotate) begin
      sample_q <= sample_i;
    end
  end

  always_comb begin
    coef_d = coef_q;
    if (ctrl_i.rotate) begin
      coef_d = coef_i;
    end else begin
      for (int b = 0; b < NumBands; b++) begin
        if (load_i[b]) coef_d[b] = coef_value_i;
      end
    end
  end

  // coefficients are undefined until loaded
  always_ff @(posedge clk_i) begin
    coef_q <= coef_d;
  end

  assign sample_o = sample_q;
  assign coef_o   = coef_q;

endmodule

### sv/three_band_fir_equalizer.sv
// Sample beat: one pass of the sample row past the three MACs (StMac), then StFlush,
// StScale and StSum; StDone loads the result once the output is free, then StIdle.
// Coefficient load beat: taken in StIdle, no result. No beat is taken outside StIdle.
// Gains reset to 1.0 and the sample row to zeros; coefficients are undefined until
// loaded. Reset is asynchronous, active low.
module three_band_fir_equalizer #(
  parameter int unsigned TAPS = eqz_pkg::TapsDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          command_i,
  input  logic signed [eqz_pkg::SampleW-1:0] sample_in_i,
  input  logic [1:0]                    coef_band_i,
  input  logic [eqz_pkg::IndexW-1:0]    coef_index_i,
  input  logic signed [eqz_pkg::CoefW-1:0] coef_value_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [eqz_pkg::SampleW-1:0] sample_out_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [1:0]                    cfg_index_i,
  input  logic [eqz_pkg::GainW-1:0]     cfg_data_i
);
  import eqz_pkg::*;

  localparam int unsigned CntW = $clog2(TAPS);

  eqz_state_e state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  logic signed [GainW-1:0] gain_q [NumBands];
  logic signed [AccW-1:0]  acc_q [NumBands];
  logic signed [AccW-1:0]  prod_q [NumBands];
  logic                    pvalid_q;
  logic signed [GprodW-1:0] gprod_q [NumBands];
  logic signed [SumW-1:0]  sum_q;
  logic signed [SampleW-1:0] out_q;
  logic                    out_valid_q;

  logic in_acc, load_out, acc_clear;
  cell_ctrl_t ctrl;

  logic [SampleW-1:0]             smp   [TAPS];
  logic [NumBands-1:0][CoefW-1:0] coefs [TAPS];
  logic [SampleW-1:0]             tail_sample;

  assign in_acc = in_valid_i && !in_stall_o;

  // config
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int b = 0; b < NumBands; b++) gain_q[b] <= GainOne;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        RegGainLow:  gain_q[0] <= cfg_data_i;
        RegGainMid:  gain_q[1] <= cfg_data_i;
        RegGainHigh: gain_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // control
  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    in_stall_o = 1'b1;
    ctrl       = '0;
    load_out   = 1'b0;
    acc_clear  = 1'b0;
    case (state_q)
      StIdle: begin
        in_stall_o = 1'b0;
        if (in_valid_i && command_i == CmdSample) begin
          ctrl.shift = 1'b1;
          acc_clear  = 1'b1;
          cnt_d      = '0;
          state_d    = StMac;
        end
      end
      StMac: begin
        ctrl.rotate = 1'b1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CntW'(TAPS - 1)) state_d = StFlush;
      end
      StFlush: state_d = StScale;
      StScale: state_d = StSum;
      StSum:   state_d = StDone;
      StDone: begin
        if (!out_valid_q || !out_stall_i) begin
          load_out = 1'b1;
          state_d  = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      cnt_q    <= '0;
      pvalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      pvalid_q <= (state_q == StMac);
    end
  end

  // row of cells; cell 0 holds the oldest sample
  assign tail_sample = ctrl.rotate ? smp[0] : sample_in_i;

  for (genvar k = 0; k < TAPS; k++) begin : g_cell
    localparam int unsigned Next = (k + 1) % TAPS;
    logic [NumBands-1:0] load;
    always_comb begin
      for (int b = 0; b < NumBands; b++) begin
        load[b] = in_acc && command_i == CmdCoef && coef_band_i == 2'(b)
                  && int'(coef_index_i) == k;
      end
    end
    eqz_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .load_i       (load),
      .coef_value_i (coef_value_i),
      .sample_i     ((k == TAPS - 1) ? tail_sample : smp[Next]),
      .coef_i       (coefs[Next]),
      .sample_o     (smp[k]),
      .coef_o       (coefs[k])
    );
  end

  // three MACs fed from the head cell
  always_ff @(posedge clk_i) begin
    for (int b = 0; b < NumBands; b++) begin
      prod_q[b] <= AccW'(signed'(coefs[0][b]) * signed'(smp[0]));
      if (acc_clear) acc_q[b] <= '0;
      else if (pvalid_q) acc_q[b] <= acc_q[b] + prod_q[b];
      if (state_q == StScale)
        gprod_q[b] <= GprodW'(BandW'((acc_q[b] + signed'(RoundConst)) >>> AccShift))
                      * gain_q[b];
    end
    if (state_q == StSum)
      sum_q <= SumW'(gprod_q[0]) + SumW'(gprod_q[1]) + SumW'(gprod_q[2]);
  end

  // truncate toward zero, then saturate
  logic signed [SumW-1:0] adj, quot;
  always_comb begin
    adj  = sum_q + (sum_q[SumW-1] ? SumW'((1 << GainShift) - 1) : SumW'(0));
    quot = adj >>> GainShift;
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      if (quot > SumW'(32767))       out_q <= 16'sh7fff;
      else if (quot < -SumW'(32768)) out_q <= 16'sh8000;
      else                           out_q <= quot[SampleW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (load_out) out_valid_q <= 1'b1;
    else if (!out_stall_i) out_valid_q <= 1'b0;
  end

  assign out_valid_o  = out_valid_q;
  assign sample_out_o = out_q;

endmodule

### tb/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import eqz_pkg::*;

  localparam int unsigned Taps       = TapsDefault;
  localparam int unsigned DrainWait  = Taps + 16;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned LongHold   = 600;

  class eq_scoreboard;
    logic signed [SampleW-1:0] ring [Taps];
    logic signed [CoefW-1:0]   coefs [NumBands*Taps];
    logic signed [GainW-1:0]   gains [NumBands];
    int unsigned               wr_pos;
    logic signed [SampleW-1:0] pending_samples [$];
    int unsigned               errors;
    int unsigned               n_samples;
    int unsigned               n_loads;
    int unsigned               n_saturated;

    function new();
      foreach (ring[i]) ring[i] = '0;
      foreach (coefs[i]) coefs[i] = '0;
      foreach (gains[i]) gains[i] = GainOne;
      wr_pos = 0;
      errors = 0;
      n_samples = 0;
      n_loads = 0;
      n_saturated = 0;
    endfunction

    function void set_gain(logic [1:0] idx, logic [GainW-1:0] val);
      gains[idx] = val;
    endfunction

    function logic signed [BandW-1:0] band_sum(int unsigned band, int unsigned oldest);
      logic signed [AccW-1:0] acc;
      int unsigned pos;
      acc = '0;
      pos = oldest;
      for (int unsigned k = 0; k < Taps; k++) begin
        acc += int'(coefs[band*Taps+k]) * int'(ring[pos]);
        pos = (pos + 1) % Taps;
      end
      acc += RoundConst;
      return acc >>> AccShift;
    endfunction

    // Note one accepted input beat and predict its output, if any.
    function void note_beat(logic cmd, logic signed [SampleW-1:0] smp, logic [1:0] band,
                            logic [IndexW-1:0] idx, logic signed [CoefW-1:0] val);
      int unsigned oldest;
      longint total;
      longint q;
      if (cmd == CmdCoef) begin
        n_loads++;
        if (band != 2'd3) coefs[band*Taps+idx] = val;
        return;
      end
      n_samples++;
      ring[wr_pos] = smp;
      oldest = (wr_pos + 1) % Taps;
      total = longint'(band_sum(BandLow, oldest)) * longint'(gains[BandLow])
            + longint'(band_sum(BandMid, oldest)) * longint'(gains[BandMid])
            + longint'(band_sum(BandHigh, oldest)) * longint'(gains[BandHigh]);
      q = total / longint'(1 << GainShift);
      if (q > 32767) begin
        q = 32767;
        n_saturated++;
      end else if (q < -32768) begin
        q = -32768;
        n_saturated++;
      end
      pending_samples.push_back(q[SampleW-1:0]);
      wr_pos = oldest;
    endfunction

    function void check_result(logic signed [SampleW-1:0] actual);
      logic signed [SampleW-1:0] want;
      if (pending_samples.size() == 0) begin
        $error("unexpected output beat: sample_out actual %0d", actual);
        errors++;
        return;
      end
      want = pending_samples.pop_front();
      if (actual !== want) begin
        $error("sample_out mismatch: expected %0d actual %0d", want, actual);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic command_i = CmdSample;
  logic signed [SampleW-1:0] sample_in_i = '0;
  logic [1:0] coef_band_i = BandLow;
  logic [IndexW-1:0] coef_index_i = '0;
  logic signed [CoefW-1:0] coef_value_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [SampleW-1:0] sample_out_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [1:0] cfg_index_i = RegGainLow;
  logic [GainW-1:0] cfg_data_i = '0;

  eq_scoreboard eq_sb = new();
  bit quiet = 1'b0;
  int unsigned hold_cycles = 0;
  int unsigned cycle_count = 0;

  three_band_fir_equalizer #(.TAPS(Taps)) u_dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("FAIL");
      $finish;
    end
  end

  // Output side: check accepted beats, then pick the stall for the next edge.
  initial begin
    int unsigned burst;
    burst = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) eq_sb.check_result(sample_out_o);
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_stall_i <= 1'b1;
      end else if (burst > 0) begin
        burst--;
        out_stall_i <= 1'b1;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(1, 10) - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  task automatic send_beat(logic cmd, logic signed [SampleW-1:0] smp, logic [1:0] band,
                           logic [IndexW-1:0] idx, logic signed [CoefW-1:0] val);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    command_i    <= cmd;
    sample_in_i  <= smp;
    coef_band_i  <= band;
    coef_index_i <= idx;
    coef_value_i <= val;
    do @(posedge clk_i); while (in_stall_o);
    eq_sb.note_beat(cmd, smp, band, idx, val);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (eq_sb.pending_samples.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  task automatic write_gain(logic [1:0] idx, logic [GainW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    eq_sb.set_gain(idx, val);
  endtask

  task automatic load_all_coefs(int unsigned mag);
    for (int unsigned b = 0; b < NumBands; b++)
      for (int unsigned k = 0; k < Taps; k++)
        send_beat(CmdCoef, '0, b[1:0], k[IndexW-1:0],
                  CoefW'($signed($urandom_range(0, 2*mag) - mag)));
  endtask

  task automatic random_beats(int unsigned count);
    for (int unsigned n = 0; n < count; n++) begin
      if ($urandom_range(0, 3) == 0)
        send_beat(CmdCoef, SampleW'($urandom), 2'($urandom), IndexW'($urandom),
                  ($urandom_range(0, 3) == 0) ? CoefW'($urandom)
                                               : CoefW'($signed($urandom_range(0, 4000) - 2000)));
      else
        send_beat(CmdSample, SampleW'($urandom), 2'($urandom), IndexW'($urandom),
                  CoefW'($urandom));
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Every coefficient is loaded before the first sample reads it.
    load_all_coefs(1000);
    // Extremes of the sample range, at reset gains.
    send_beat(CmdSample, 16'sh7fff, BandLow, '0, '0);
    send_beat(CmdSample, -16'sh8000, BandLow, '0, '0);
    send_beat(CmdSample, '0, BandLow, '0, '0);
    send_beat(CmdSample, -16'sd1, BandLow, '0, '0);
    // Band code three is dropped; extreme coefficients drive saturation.
    send_beat(CmdCoef, '0, 2'd3, '0, 16'sh7fff);
    send_beat(CmdCoef, '0, BandHigh, 6'd63, 16'sh7fff);
    send_beat(CmdCoef, '0, BandMid, 6'd0, -16'sh8000);
    send_beat(CmdCoef, '0, BandLow, 6'd62, 16'sh7fff);
    for (int i = 0; i < 6; i++) begin
      send_beat(CmdSample, 16'sh7fff, BandLow, '0, '0);
      send_beat(CmdSample, -16'sh8000, BandLow, '0, '0);
    end

    // Long output hold: input side fills and stalls.
    hold_cycles = LongHold;
    random_beats(40);
    drain();

    write_gain(RegGainLow, 16'h7fff);
    write_gain(RegGainMid, 16'h8000);
    write_gain(RegGainHigh, '0);
    random_beats(40);
    drain();

    write_gain(RegGainLow, 16'h8000);
    write_gain(RegGainMid, 16'h7fff);
    write_gain(RegGainHigh, 16'h8000);
    random_beats(40);
    drain();

    write_gain(RegGainLow, GainW'($urandom));
    write_gain(RegGainMid, GainW'($urandom));
    write_gain(RegGainHigh, 16'h7fff);
    random_beats(40);
    drain();

    write_gain(RegGainLow, GainOne);
    write_gain(RegGainMid, GainW'($urandom_range(0, 8192)));
    write_gain(RegGainHigh, GainW'($urandom_range(0, 8192)));
    random_beats(40);

    // Last stretch without idling on either side.
    quiet = 1'b1;
    random_beats(20);
    drain();

    $display("run: %0d samples, %0d coefficient loads, %0d saturated outputs",
             eq_sb.n_samples, eq_sb.n_loads, eq_sb.n_saturated);
    $display("gain sets at reset, both extremes and random values; long output hold applied");
    if (eq_sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
